FILE: sv/interval_set_merge_query_macros.svh
// assertion helpers, clocked on aclk and disabled while aresetn is low
`ifndef INTERVAL_SET_MERGE_QUERY_MACROS_SVH
`define INTERVAL_SET_MERGE_QUERY_MACROS_SVH

// same-cycle implication
`define ISQ_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("isq assertion failed");

// next-cycle implication
`define ISQ_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("isq assertion failed");

`endif

FILE: sv/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg
// types and constants of the interval set merge and query block
// ----------------------------------------------------------------------------
`default_nettype none

package isq_pkg;

    localparam logic [31:0] MODULUS   = 32'd1000000007;
    localparam logic [31:0] MODULUS_2 = 32'd2000000014;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } in_word_t;

    typedef struct packed {
        logic [29:0] sum_mod;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic signed [31:0] ival_start;
        logic signed [31:0] ival_end;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EVAL,
        S_DECIDE,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_FINISH,
        S_Q_RD,
        S_Q_EVAL,
        S_Q_MUL,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: sv/isq_mem.sv
// ----------------------------------------------------------------------------
// isq_mem
// interval table memory, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module isq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  isq_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output isq_pkg::entry_t rdata
);
    import isq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/isq_trimod.sv
// ----------------------------------------------------------------------------
// isq_trimod
// len*(len+1)/2 mod 1000000007, shift-and-add over 33 multiplier bits
// ----------------------------------------------------------------------------
`default_nettype none

module isq_trimod (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] len,
    output logic        done,
    output logic [29:0] prod
);
    import isq_pkg::*;

    logic [32:0] x_reg, x_next;
    logic [29:0] y_reg, y_next;
    logic [29:0] acc_reg, acc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [32:0] len_p1;
    logic [32:0] big;
    logic [31:0] small_raw;
    logic [31:0] small_red;
    logic [31:0] t;
    logic [31:0] t_red;

    always_comb begin
        len_p1 = len + 33'd1;
        // the even one of len and len+1 is halved
        if (!len[0]) begin
            big       = len_p1;
            small_raw = len[32:1];
        end else begin
            big       = len;
            small_raw = len_p1[32:1];
        end
        if (small_raw >= MODULUS_2) begin
            small_red = small_raw - MODULUS_2;
        end else if (small_raw >= MODULUS) begin
            small_red = small_raw - MODULUS;
        end else begin
            small_red = small_raw;
        end

        t = {1'b0, acc_reg, 1'b0} + (x_reg[32] ? {2'b00, y_reg} : 32'd0);
        if (t >= MODULUS_2) begin
            t_red = t - MODULUS_2;
        end else if (t >= MODULUS) begin
            t_red = t - MODULUS;
        end else begin
            t_red = t;
        end

        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = big;
            y_next    = small_red[29:0];
            acc_next  = '0;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next   = {x_reg[31:0], 1'b0};
            acc_next = t_red[29:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

FILE: sv/interval_set_merge_query.sv
// ----------------------------------------------------------------------------
// interval_set_merge_query
// sorted table of disjoint closed intervals with merging insert and range sum
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one word per item: mode 0 inserts [lo,hi], mode 1 queries
//   the sum of len*(len+1)/2 mod 1000000007 over intervals inside [lo,hi]
//   m_ channel returns exactly one word per item: sum_mod and status
//   (ok, table full and insert dropped, insert with lo greater than hi)
// processing (one item at a time):
//   insert: scans the stored entries, then moves entries one at a time, each
//     by a read then a write; a covered insert stops at the covering entry
//   query: visits entries in order and waits on the serial mod-multiplier
//     for each interval summed; the walk stops at the first end past hi
//   both are paced by the single table memory read port and the
//   read-then-write move of one entry at a time
// reset: interval count goes to zero, no clearing pass; table contents
//   are only read below the count
// stall: a finished word waits in the output register; the next item is
//   accepted and worked on meanwhile, and holds at its end until m_ready
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_merge_query #(
    parameter int CAPACITY = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  isq_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output isq_pkg::out_word_t m_data
);
    import isq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg, m_valid_next;

    // per-item working registers
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      first_reg, first_next;
    logic [CW-1:0]      lastraw_reg, lastraw_next;
    logic               first_found_reg, first_found_next;
    logic               last_found_reg, last_found_next;
    logic [CW-1:0]      removed_reg, removed_next;
    logic               right_reg, right_next;
    logic               mode_reg, mode_next;
    logic signed [31:0] lo_reg, lo_next;
    logic signed [31:0] hi_reg, hi_next;
    logic signed [31:0] sf_reg, sf_next;
    logic signed [31:0] el_reg, el_next;
    entry_t             put_reg, put_next;
    logic [1:0]         status_reg, status_next;
    logic [29:0]        sum_reg, sum_next;
    out_word_t          m_data_reg, m_data_next;

    // memory and multiplier hookups
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        rd;
    logic          tri_start;
    logic          tri_done;
    logic [29:0]   tri_prod;
    logic [32:0]   tri_len;

    // comparisons on the word just read, at 33 bits so lo-1 and hi+1 do not wrap
    logic signed [32:0] rs33, re33, lo33, hi33, lo_m1, hi_p1;
    logic [CW-1:0]      first_v, last_v, last_sel;
    logic [CW:0]        src_far;
    logic [30:0]        sum_add;
    logic               out_free;

    assign rs33    = {rd.ival_start[31], rd.ival_start};
    assign re33    = {rd.ival_end[31], rd.ival_end};
    assign lo33    = {lo_reg[31], lo_reg};
    assign hi33    = {hi_reg[31], hi_reg};
    assign lo_m1   = lo33 - 33'sd1;
    assign hi_p1   = hi33 + 33'sd1;
    assign tri_len = 33'(re33 - rs33) + 33'd1;
    assign first_v = first_found_reg ? first_reg : count_reg;
    assign last_v  = last_found_reg ? lastraw_reg : count_reg;
    assign last_sel = (last_v > first_v) ? last_v : first_v;
    assign src_far = {1'b0, idx_reg} + {1'b0, removed_reg};
    assign sum_add = {1'b0, sum_reg} + {1'b0, tri_prod};
    assign out_free = !m_valid_reg || m_ready;

    isq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    isq_trimod u_trimod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tri_start),
        .len     (tri_len),
        .done    (tri_done),
        .prod    (tri_prod)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.mode == MODE_QUERY) begin
                        state_next = S_Q_RD;
                    end else if (s_data.lo > s_data.hi) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD:   state_next = (idx_reg < count_reg) ? S_INS_EVAL : S_DECIDE;
            S_INS_EVAL: begin
                if (rd.ival_start <= lo_reg && hi_reg <= rd.ival_end) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_DECIDE: begin
                if (last_sel == first_v) begin
                    state_next = (count_reg == CW'(CAPACITY)) ? S_OUT : S_MV_RD;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_MV_RD: begin
                if (right_reg) begin
                    state_next = (idx_reg > first_reg) ? S_MV_WR : S_PUT;
                end else begin
                    state_next = (src_far < {1'b0, count_reg}) ? S_MV_WR : S_FINISH;
                end
            end
            S_MV_WR:  state_next = S_MV_RD;
            S_PUT:    state_next = right_reg ? S_FINISH : S_MV_RD;
            S_FINISH: state_next = S_OUT;
            S_Q_RD:   state_next = (idx_reg < count_reg) ? S_Q_EVAL : S_OUT;
            S_Q_EVAL: begin
                if (rd.ival_start < lo_reg) begin
                    state_next = S_Q_RD;
                end else if (rd.ival_end <= hi_reg) begin
                    state_next = S_Q_MUL;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_Q_MUL:  state_next = tri_done ? S_Q_RD : S_Q_MUL;
            S_OUT:    state_next = out_free ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory, multiplier and handshake controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = rd;
        mem_raddr = idx_reg[AW-1:0];
        tri_start = 1'b0;
        s_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_MV_RD: begin
                if (right_reg) begin
                    mem_raddr = AW'(idx_reg - CW'(1));
                end else begin
                    mem_raddr = src_far[AW-1:0];
                end
            end
            S_MV_WR: mem_we = 1'b1;
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = first_reg[AW-1:0];
                mem_wdata = put_reg;
            end
            S_Q_EVAL: begin
                tri_start = (rd.ival_start >= lo_reg) && (rd.ival_end <= hi_reg);
            end
            default: begin
            end
        endcase
    end

    // working registers
    always_comb begin
        count_next       = count_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        idx_next         = idx_reg;
        first_next       = first_reg;
        lastraw_next     = lastraw_reg;
        first_found_next = first_found_reg;
        last_found_next  = last_found_reg;
        removed_next     = removed_reg;
        right_next       = right_reg;
        mode_next        = mode_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        sf_next          = sf_reg;
        el_next          = el_reg;
        put_next         = put_reg;
        status_next      = status_reg;
        sum_next         = sum_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next        = s_data.mode;
                    lo_next          = s_data.lo;
                    hi_next          = s_data.hi;
                    idx_next         = '0;
                    first_found_next = 1'b0;
                    last_found_next  = 1'b0;
                    sum_next         = '0;
                    status_next      = (s_data.mode == MODE_INSERT && s_data.lo > s_data.hi)
                                       ? STATUS_RANGE : STATUS_OK;
                end
            end
            S_INS_EVAL: begin
                // first entry reaching lo-1, first entry starting past hi+1
                if (!first_found_reg && re33 >= lo_m1) begin
                    first_found_next = 1'b1;
                    first_next       = idx_reg;
                    sf_next          = rd.ival_start;
                end
                if (!last_found_reg && rs33 > hi_p1) begin
                    last_found_next = 1'b1;
                    lastraw_next    = idx_reg;
                end
                if (rs33 <= hi_p1) begin
                    el_next = rd.ival_end;
                end
                idx_next = idx_reg + CW'(1);
            end
            S_DECIDE: begin
                first_next = first_v;
                if (last_sel == first_v) begin
                    if (count_reg == CW'(CAPACITY)) begin
                        status_next = STATUS_FULL;
                    end
                    right_next = 1'b1;
                    idx_next   = count_reg;
                    put_next   = '{ival_start: lo_reg, ival_end: hi_reg};
                end else begin
                    right_next   = 1'b0;
                    idx_next     = first_v + CW'(1);
                    removed_next = last_sel - first_v - CW'(1);
                    put_next     = '{ival_start: (sf_reg < lo_reg) ? sf_reg : lo_reg,
                                     ival_end:   (el_reg > hi_reg) ? el_reg : hi_reg};
                end
            end
            S_MV_WR: idx_next = right_reg ? idx_reg - CW'(1) : idx_reg + CW'(1);
            S_FINISH: begin
                count_next = right_reg ? count_reg + CW'(1) : count_reg - removed_reg;
            end
            S_Q_EVAL: begin
                if (rd.ival_start < lo_reg) begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_Q_MUL: begin
                if (tri_done) begin
                    sum_next = (sum_add >= 31'(MODULUS)) ? 30'(sum_add - 31'(MODULUS))
                                                         : sum_add[29:0];
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{sum_mod: (mode_reg == MODE_QUERY) ? sum_reg : 30'd0,
                                     status:  status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg      <= m_data_next;
        idx_reg         <= idx_next;
        first_reg       <= first_next;
        lastraw_reg     <= lastraw_next;
        first_found_reg <= first_found_next;
        last_found_reg  <= last_found_next;
        removed_reg     <= removed_next;
        right_reg       <= right_next;
        mode_reg        <= mode_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        sf_reg          <= sf_next;
        el_reg          <= el_next;
        put_reg         <= put_next;
        status_reg      <= status_next;
        sum_reg         <= sum_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `include "interval_set_merge_query_macros.svh"

    // the table never holds more than its capacity
    `ISQ_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY))
    // a dropped insert is reported only against a full table
    `ISQ_ASSERT_IMP(a_full_only_full, state_reg == S_OUT && status_reg == STATUS_FULL,
        count_reg == CW'(CAPACITY))
    // the count moves only when an insert finishes
    `ISQ_ASSERT_NXT(a_count_hold, state_reg != S_FINISH, $stable(count_reg))
    // a product arrives only while the query waits for it
    `ISQ_ASSERT_IMP(a_tri_done_state, tri_done, state_reg == S_Q_MUL)

endmodule

`default_nettype wire

FILE: sim/interval_set_merge_query_tb.sv
// ----------------------------------------------------------------------------
// interval_set_merge_query_tb
// drives insert and query words into the interval table and checks each
// result word against a behavioral model of the sorted interval table
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_merge_query_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isq_pkg::*;

    localparam int CAP = 64;
    localparam longint MOD = 64'd1000000007;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    interval_set_merge_query #(.CAPACITY(CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // model of the table, kept at 64 bits so lo-1 and hi+1 never wrap
    longint    tbl_start[CAP];
    longint    tbl_end[CAP];
    int        tbl_count;

    out_word_t pending_results[$];
    int        n_errors;
    bit        stim_done;
    bit        hold_off;

    // directed rows: word plus an optional typed-in expected result
    typedef struct {
        in_word_t  w;
        bit        has_exp;
        out_word_t exp;
    } row_t;

    row_t dir_rows[$];

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    function automatic void add_row(in_word_t w, bit has_exp, out_word_t exp_word);
        row_t r;
        r.w       = w;
        r.has_exp = has_exp;
        r.exp     = exp_word;
        dir_rows  = {dir_rows, r};
    endfunction

    function automatic longint tri_sum(longint len);
        longint a, b;
        a = len;
        b = len + 1;
        if (a[0] == 1'b0) a = a >>> 1;
        else b = b >>> 1;
        return ((a % MOD) * (b % MOD)) % MOD;
    endfunction

    function automatic logic [1:0] table_insert(longint lo, longint hi);
        int first, last, removed;
        longint ns, ne;
        if (lo > hi) return STATUS_RANGE;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_start[i] <= lo && hi <= tbl_end[i]) return STATUS_OK;
        first = 0;
        while (first < tbl_count && tbl_end[first] < lo - 1) first++;
        last = first;
        while (last < tbl_count && tbl_start[last] <= hi + 1) last++;
        if (last == first) begin
            if (tbl_count >= CAP) return STATUS_FULL;
            for (int i = tbl_count; i > first; i--) begin
                tbl_start[i] = tbl_start[i-1];
                tbl_end[i]   = tbl_end[i-1];
            end
            tbl_start[first] = lo;
            tbl_end[first]   = hi;
            tbl_count++;
            return STATUS_OK;
        end
        ns = (tbl_start[first] < lo) ? tbl_start[first] : lo;
        ne = (tbl_end[last-1] > hi) ? tbl_end[last-1] : hi;
        tbl_start[first] = ns;
        tbl_end[first]   = ne;
        removed = last - first - 1;
        for (int i = first + 1; i + removed < tbl_count; i++) begin
            tbl_start[i] = tbl_start[i+removed];
            tbl_end[i]   = tbl_end[i+removed];
        end
        tbl_count -= removed;
        return STATUS_OK;
    endfunction

    function automatic longint range_sum(longint lo, longint hi);
        int i;
        longint acc;
        i = 0;
        acc = 0;
        while (i < tbl_count && tbl_start[i] < lo) i++;
        while (i < tbl_count && tbl_end[i] <= hi) begin
            acc = (acc + tri_sum(tbl_end[i] - tbl_start[i] + 1)) % MOD;
            i++;
        end
        return acc;
    endfunction

    function automatic out_word_t predict_result(in_word_t w);
        out_word_t r;
        longint lo, hi;
        lo = longint'(w.lo);
        hi = longint'(w.hi);
        r = '0;
        if (w.mode == MODE_QUERY) r.sum_mod = 30'(range_sum(lo, hi));
        else r.status = table_insert(lo, hi);
        return r;
    endfunction

    // send one word, holding valid and payload until accepted
    task automatic send_word(in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_gap(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic in_word_t mk(logic m, int lo, int hi);
        in_word_t w;
        w.mode = m;
        w.lo = lo;
        w.hi = hi;
        return w;
    endfunction

    // random bounds: mostly small clustered values so merges happen,
    // sometimes full-range values to toggle every bit
    function automatic int rnd_bound(int base);
        case ($urandom_range(0, 9))
            0:       return int'($urandom);
            1:       return base + int'($urandom_range(0, 200000));
            default: return base + int'($urandom_range(0, 3000));
        endcase
    endfunction

    // random word: insert or query over clustered bounds, sometimes lo>hi or a full-range query
    function automatic in_word_t rnd_word(int base);
        in_word_t w;
        int a, b;
        a = rnd_bound(base);
        b = ($urandom_range(0, 15) == 0) ? rnd_bound(base)
                                         : a + int'($urandom_range(0, 40));
        if (b < a && $urandom_range(0, 3) != 0) begin
            int t;
            t = a; a = b; b = t;
        end
        w.mode = ($urandom_range(0, 2) == 0) ? MODE_QUERY : MODE_INSERT;
        w.lo = a;
        w.hi = b;
        if (w.mode == MODE_QUERY && $urandom_range(0, 4) == 0) begin
            w.lo = 32'sh8000_0000;
            w.hi = 32'sh7fff_ffff;
        end
        return w;
    endfunction

    // record expectation at acceptance time
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_results = {pending_results, predict_result(s_data)};
    end

    // result checker
    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation: %h", m_data);
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_data.sum_mod !== e.sum_mod) begin
                    $error("sum_mod expected %0d actual %0d", e.sum_mod, m_data.sum_mod);
                    n_errors++;
                end
                if (m_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_data.status);
                    n_errors++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        wait (stim_done == 1'b0 && aresetn);
        repeat (3000) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (600) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // limit
    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        row_t r;
        in_word_t w;
        int base, burst, waited;

        n_errors  = 0;
        stim_done = 1'b0;
        tbl_count = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: empty table, extremes, lo>hi, merge, cover, touch
        add_row(mk(MODE_QUERY, 32'sh8000_0000, 32'sh7fff_ffff), 1, '{0, STATUS_OK});
        add_row(mk(MODE_INSERT, 5, 4), 1, '{0, STATUS_RANGE});
        add_row(mk(MODE_QUERY, 5, 4), 1, '{0, STATUS_OK});
        add_row(mk(MODE_INSERT, 32'sh8000_0000, 32'sh8000_0000), 1, '{0, STATUS_OK});
        add_row(mk(MODE_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff), 1, '{0, STATUS_OK});
        add_row(mk(MODE_QUERY, 32'sh8000_0000, 32'sh7fff_ffff), 1, '{2, STATUS_OK});
        add_row(mk(MODE_INSERT, 10, 20), 0, '0);
        add_row(mk(MODE_INSERT, 12, 15), 0, '0);   // covered
        add_row(mk(MODE_INSERT, 21, 25), 0, '0);   // touches right
        add_row(mk(MODE_INSERT, 5, 9), 0, '0);     // touches left
        add_row(mk(MODE_INSERT, 40, 50), 0, '0);
        add_row(mk(MODE_INSERT, 30, 35), 0, '0);
        add_row(mk(MODE_INSERT, 24, 41), 0, '0);   // merges several
        add_row(mk(MODE_QUERY, 0, 100), 0, '0);
        add_row(mk(MODE_QUERY, 6, 100), 0, '0);
        add_row(mk(MODE_INSERT, 32'sh8000_0001, 32'sh7fff_fffe), 0, '0);
        add_row(mk(MODE_QUERY, 32'sh8000_0000, 32'sh7fff_ffff), 0, '0);
        add_row(mk(MODE_QUERY, -1, -2), 0, '0);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.has_exp) begin
                // typed-in result must agree with the model too
                s_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge aclk);
            end
            send_word(r.w);
            if (r.has_exp) begin
                @(negedge aclk);
                if (pending_results[$] !== r.exp) begin
                    $error("directed row %0d expected %h model %h", i, r.exp,
                           pending_results[$]);
                    n_errors++;
                end
            end
        end
        idle_gap(2);

        // random part in phases; each phase fills a fresh region
        base = -50000;
        for (int n = 0; n < 640; ) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && n < 640; k++, n++) begin
                if (n % 160 == 0) base = int'($urandom_range(0, 1000000)) - 500000;
                w = rnd_word(base);
                // push sparse singles when full-table drops are wanted
                if (n % 160 > 100 && w.mode == MODE_INSERT) begin
                    w.lo = base + 10000 + int'($urandom_range(0, 400)) * 5;
                    w.hi = w.lo + int'($urandom_range(0, 2));
                end
                send_word(w);
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
        end
        s_valid   <= 1'b0;
        stim_done <= 1'b1;

        waited = 0;
        while (pending_results.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (400) @(posedge aclk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d results never arrived", pending_results.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/isq_pkg.sv
sv/isq_mem.sv
sv/isq_trimod.sv
sv/interval_set_merge_query.sv
sim/interval_set_merge_query_tb.sv
